// ===== hdl/pds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants of the periodic derivative stencil
// Widths of the sample, weight and scale paths, register indexes, the
// sequencer states and the datapath command set.
// ----------------------------------------------------------------------------
package pds_pkg;

    // field widths
    localparam int SAMPLE_W   = 32;
    localparam int WEIGHT_W   = 24;
    localparam int SCALE_W    = 32;
    localparam int LEN_W      = 13;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // sample store: seven recent samples followed by the six head samples
    localparam int WIN_D   = 7;
    localparam int HEAD_D  = 6;
    localparam int STORE_D = WIN_D + HEAD_D;

    // line length limits
    localparam int MIN_LENGTH     = 7;
    localparam int MAX_LENGTH_DEF = 4096;

    // results of a line end: the centre, positions N-3..N-1, then 0, 1, 2
    localparam int WRAP_RESULTS = 7;
    localparam int HEAD_RESULTS = 3;
    localparam int LEFT_W       = 3;

    // datapath widths
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int MA_W        = DIFF_W + 1;
    localparam int MB_W        = SCALE_W + 1;
    localparam int PROD_W      = MA_W + MB_W;
    localparam int ACC_W       = 59;
    localparam int MAG_W       = ACC_W - 1;
    localparam int LO_W        = 32;
    localparam int HI_W        = MAG_W - LO_W;
    localparam int HIP_W       = HI_W + SCALE_W;
    localparam int RND_BIT     = 37;
    localparam int FINAL_SHIFT = 6;
    localparam int RMAG_W      = HIP_W + 1 - FINAL_SHIFT;

    // reset values
    localparam logic [SCALE_W-1:0] INV_SPACING_RST = SCALE_W'(65536);
    localparam logic [LEN_W-1:0]   LINE_LENGTH_RST = LEN_W'(64);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_NEAR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_W0,
        S_W1,
        S_W2,
        S_SUM,
        S_MAG,
        S_LO,
        S_HI,
        S_RND,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_MUL_FIRST,
        DP_MUL_ACC,
        DP_ACC,
        DP_MAG,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_ROUND
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd cmd;
    } t_dp_ctrl;

endpackage

// ===== hdl/periodic_derivative_stencil_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_derivative_stencil_unit: sixth-order periodic stencil right-hand side
// Streams one grid line, keeps a seven-sample window and the first six samples,
// and emits inv_spacing * sum of weighted centred differences per position.
//
//  channel   signals                                         direction
//  sample    i_sample_valid / o_sample_ready, i_sample         in
//  result    o_result_valid / i_result_ready, o_derivative,    out
//            o_position, o_line_done
//  config    i_cfg_we, i_cfg_index, i_cfg_data                  in, write only
//
//  A sample that yields no result frees the block at once; one that yields
//  results holds it until its last result is registered. Each result steps
//  the shared multiplier through three weighted differences, two scale partial
//  products, round and saturate; a mid-line sample yields one, a line's last seven.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A stalled result register holds the sequencer in its final step only.
// ----------------------------------------------------------------------------
module periodic_derivative_stencil_unit import pds_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_sample_valid,
    output logic                        o_sample_ready,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    output logic                        o_result_valid,
    input  logic                        i_result_ready,
    output logic signed [SAMPLE_W-1:0]  o_derivative,
    output logic [POS_W-1:0]            o_position,
    output logic                        o_line_done
);

    localparam int CntW = $clog2(MAX_LENGTH);
    localparam int EffW = (CntW + 1 > LEN_W) ? CntW + 1 : LEN_W;

    // configuration registers
    logic signed [WEIGHT_W-1:0] r_weight_near;
    logic signed [WEIGHT_W-1:0] r_weight_mid;
    logic signed [WEIGHT_W-1:0] r_weight_far;
    logic [SCALE_W-1:0]         r_inv_spacing;
    logic [LEN_W-1:0]           r_line_length;

    // control state
    t_state                     r_state, n_state;
    logic [CntW-1:0]            r_cnt;
    logic [LEFT_W-1:0]          r_left;
    logic                       r_wrap;
    logic                       r_out_valid;

    // payload
    logic [SAMPLE_W-1:0]        r_win [STORE_D];
    logic signed [DIFF_W-1:0]   r_diff;
    logic [POS_W-1:0]           r_pos;
    logic [SAMPLE_W-1:0]        r_out_deriv;
    logic [POS_W-1:0]           r_out_pos;
    logic                       r_out_done;

    logic                       accept;
    logic                       out_free;
    logic                       emit;
    logic [EffW-1:0]            len_ext;
    logic [EffW-1:0]            len_eff;
    logic [EffW-1:0]            cnt_next;
    logic                       is_last;
    logic [SAMPLE_W-1:0]        tap_hi;
    logic [SAMPLE_W-1:0]        tap_lo;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [WEIGHT_W-1:0] weight_sel;
    logic [SAMPLE_W-1:0]        dp_result;
    t_dp_ctrl                   dp_ctrl;

    assign o_sample_ready = (r_state == S_IDLE);
    assign accept         = i_sample_valid && o_sample_ready;
    assign out_free       = !r_out_valid || i_result_ready;
    assign emit           = (r_state == S_OUT) && out_free;

    assign o_result_valid = r_out_valid;
    assign o_derivative   = r_out_deriv;
    assign o_position     = r_out_pos;
    assign o_line_done    = r_out_done;

    // length in force, clamped, and end-of-line detect
    always_comb begin
        len_ext = EffW'(r_line_length);
        if (len_ext < EffW'(MIN_LENGTH)) begin
            len_eff = EffW'(MIN_LENGTH);
        end else if (len_ext > EffW'(MAX_LENGTH)) begin
            len_eff = EffW'(MAX_LENGTH);
        end else begin
            len_eff = len_ext;
        end
        cnt_next = EffW'(r_cnt) + EffW'(1);
        is_last  = (cnt_next >= len_eff);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_near <= '0;
            r_weight_mid  <= '0;
            r_weight_far  <= '0;
            r_inv_spacing <= INV_SPACING_RST;
            r_line_length <= LINE_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WEIGHT_NEAR: r_weight_near <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_MID:  r_weight_mid  <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_FAR:  r_weight_far  <= i_cfg_data[WEIGHT_W-1:0];
                CFG_INV_SPACING: r_inv_spacing <= i_cfg_data[SCALE_W-1:0];
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // difference taps around the window centre and weight select
    always_comb begin
        case (r_state)
            S_W0: begin
                tap_hi = r_win[5];
                tap_lo = r_win[1];
            end
            S_W1: begin
                tap_hi = r_win[6];
                tap_lo = r_win[0];
            end
            default: begin
                tap_hi = r_win[4];
                tap_lo = r_win[2];
            end
        endcase
        diff = $signed({tap_hi[SAMPLE_W-1], tap_hi}) - $signed({tap_lo[SAMPLE_W-1], tap_lo});
        case (r_state)
            S_W1:    weight_sel = r_weight_mid;
            S_W2:    weight_sel = r_weight_far;
            default: weight_sel = r_weight_near;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state and datapath command
    always_comb begin
        n_state     = r_state;
        dp_ctrl.cmd = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (is_last || r_cnt >= CntW'(HEAD_D))) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = S_W0;
            S_W0: begin
                dp_ctrl.cmd = DP_MUL_FIRST;
                n_state     = S_W1;
            end
            S_W1: begin
                dp_ctrl.cmd = DP_MUL_ACC;
                n_state     = S_W2;
            end
            S_W2: begin
                dp_ctrl.cmd = DP_MUL_ACC;
                n_state     = S_SUM;
            end
            S_SUM: begin
                dp_ctrl.cmd = DP_ACC;
                n_state     = S_MAG;
            end
            S_MAG: begin
                dp_ctrl.cmd = DP_MAG;
                n_state     = S_LO;
            end
            S_LO: begin
                dp_ctrl.cmd = DP_MUL_LO;
                n_state     = S_HI;
            end
            S_HI: begin
                dp_ctrl.cmd = DP_MUL_HI;
                n_state     = S_RND;
            end
            S_RND: begin
                dp_ctrl.cmd = DP_ROUND;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = (r_left == LEFT_W'(1)) ? S_IDLE : S_DIFF;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // line count, result count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_left      <= '0;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt  <= is_last ? '0 : r_cnt + CntW'(1);
                r_wrap <= is_last;
                r_left <= is_last ? LEFT_W'(WRAP_RESULTS) : LEFT_W'(1);
            end else if (emit) begin
                r_left <= r_left - LEFT_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample store, positions and result register
    always_ff @(posedge i_clk) begin
        r_diff <= diff;
        if (accept) begin
            for (int i = 0; i < WIN_D - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_D-1] <= i_sample;
            for (int j = 0; j < HEAD_D; j++) begin
                if (r_cnt == CntW'(j)) begin
                    r_win[WIN_D+j] <= i_sample;
                end
            end
            r_pos <= POS_W'(r_cnt) - POS_W'(HEAD_RESULTS);
        end else if (emit) begin
            // line end: slide the whole store so the next centre is at a fixed tap
            if (r_wrap && r_left != LEFT_W'(1)) begin
                for (int i = 0; i < STORE_D - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
            end
            r_pos <= (r_left == LEFT_W'(HEAD_RESULTS + 1)) ? '0 : r_pos + POS_W'(1);
        end
        if (emit) begin
            r_out_deriv <= dp_result;
            r_out_pos   <= r_pos;
            r_out_done  <= r_wrap && (r_left == LEFT_W'(1));
        end
    end

    pds_datapath u_datapath (
        .i_clk    (i_clk),
        .i_ctrl   (dp_ctrl),
        .i_diff   (r_diff),
        .i_weight (weight_sel),
        .i_scale  (r_inv_spacing),
        .o_result (dp_result)
    );

    // checks
    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_left != '0))
        else $error("sequencer busy with no result pending");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && !r_wrap) |-> (r_left == LEFT_W'(1)))
        else $error("mid-line sample with more than one result");

    a_wrap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_wrap) |-> (r_cnt == '0))
        else $error("line count not restarted at line end");

    a_done_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_line_done) |-> (o_position == POS_W'(HEAD_RESULTS - 1)))
        else $error("line end marked on a wrong position");

    a_out_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_result_ready) |=> (r_state == S_OUT))
        else $error("result overwritten while stalled");

endmodule

// ===== hdl/pds_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_datapath: shared multiplier, accumulator, scaling and saturation
// One 34x33 signed multiplier serves the three weighted differences and the
// two partial products of the spacing scale, stepped by the sequencer.
// ----------------------------------------------------------------------------
module pds_datapath import pds_pkg::*; (
    input  logic                        i_clk,
    input  t_dp_ctrl                    i_ctrl,
    input  logic signed [DIFF_W-1:0]    i_diff,
    input  logic signed [WEIGHT_W-1:0]  i_weight,
    input  logic [SCALE_W-1:0]          i_scale,
    output logic [SAMPLE_W-1:0]         o_result
);

    localparam logic [2*LO_W:0]    RndBias  = (2*LO_W+1)'(1) << RND_BIT;
    localparam logic [SAMPLE_W-1:0] SatPos  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SatNeg  = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [2*LO_W:0]          lo_rnd;
    logic [HIP_W:0]           round_q;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [2*LO_W-1:0]        r_lo;
    logic [RMAG_W-1:0]        r_rmag;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = {{(MA_W-DIFF_W){i_diff[DIFF_W-1]}}, i_diff};
        mul_b = {{(MB_W-WEIGHT_W){i_weight[WEIGHT_W-1]}}, i_weight};
        case (i_ctrl.cmd)
            DP_MUL_LO: begin
                mul_a = {{(MA_W-LO_W){1'b0}}, r_mag[LO_W-1:0]};
                mul_b = {1'b0, i_scale};
            end
            DP_MUL_HI: begin
                mul_a = {{(MA_W-HI_W){1'b0}}, r_mag[MAG_W-1:LO_W]};
                mul_b = {1'b0, i_scale};
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // rounding: (hi<<32 + lo + 2^37) >> 38, half away from zero on magnitude
    always_comb begin
        lo_rnd  = {1'b0, r_lo} + RndBias;
        round_q = (HIP_W+1)'(r_prod[HIP_W-1:0]) + (HIP_W+1)'(lo_rnd[2*LO_W:LO_W]);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.cmd)
            DP_MUL_FIRST: begin
                r_prod <= mul_p;
                r_acc  <= '0;
            end
            DP_MUL_ACC: begin
                r_prod <= mul_p;
                r_acc  <= r_acc + ACC_W'(r_prod);
            end
            DP_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            DP_MAG: begin
                r_neg <= r_acc[ACC_W-1];
                r_mag <= r_acc[ACC_W-1] ? MAG_W'(-r_acc) : MAG_W'(r_acc);
            end
            DP_MUL_LO: begin
                r_prod <= mul_p;
            end
            DP_MUL_HI: begin
                r_prod <= mul_p;
                r_lo   <= r_prod[2*LO_W-1:0];
            end
            DP_ROUND: begin
                r_rmag <= round_q[HIP_W:FINAL_SHIFT];
            end
            default: ;
        endcase
    end

    // saturate and restore the sign
    always_comb begin
        if (!r_neg) begin
            o_result = (r_rmag > RMAG_W'(SatPos)) ? SatPos : r_rmag[SAMPLE_W-1:0];
        end else begin
            o_result = (r_rmag > RMAG_W'(SatNeg)) ? SatNeg
                     : SAMPLE_W'(0) - r_rmag[SAMPLE_W-1:0];
        end
    end

endmodule
